### src/bbs_pkg.sv
// bbs_pkg: shared types, constants and fixed-point helpers of the bouncing ball step block.
// Used by bbs_mul, bbs_div and bouncing_ball_step_top; depends on nothing.
package bbs_pkg;

  // default number of fraction bits of positions and velocities
  localparam int FRAC_BITS_DEF = 8;

  // fixed field widths
  localparam int POS_W     = 20;
  localparam int VEL_W     = 24;
  localparam int MUL_W     = 24;
  localparam int DIV_STEPS = 24;

  localparam logic [POS_W-1:0]        POS_MAX     = 20'hFFFFF;
  localparam logic signed [VEL_W-1:0] VEL_MAX     = 24'sh7FFFFF;
  localparam logic signed [VEL_W-1:0] VEL_MIN     = -24'sh800000;
  localparam logic [VEL_W-1:0]        VEL_MAG_LIM = 24'h800000;

  // register reset values
  localparam logic [11:0] AREA_WIDTH_RST  = 12'd800;
  localparam logic [11:0] AREA_HEIGHT_RST = 12'd600;
  localparam logic [7:0]  RADIUS_RST      = 8'd20;
  localparam logic [15:0] GRAVITY_RST     = 16'd980;
  localparam logic [15:0] RESTITUTION_RST = 16'd52429;
  localparam int unsigned POS_X_RST_PIX   = 400;
  localparam int unsigned POS_Y_RST_PIX   = 100;

  // register indexes
  typedef enum logic [2:0] {
    CFG_AREA_WIDTH  = 3'd0,
    CFG_AREA_HEIGHT = 3'd1,
    CFG_RADIUS      = 3'd2,
    CFG_GRAVITY     = 3'd3,
    CFG_RESTITUTION = 3'd4
  } cfg_idx_t;

  // input item
  typedef struct packed {
    logic [15:0] frame_time;
    logic [11:0] mouse_x;
    logic [11:0] mouse_y;
    logic        button_pressed;
    logic        button_released;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [POS_W-1:0]        ball_x;
    logic [POS_W-1:0]        ball_y;
    logic signed [VEL_W-1:0] speed_x;
    logic signed [VEL_W-1:0] speed_y;
    logic                    held;
  } out_item_t;

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_GRAB_A,
    ST_GRAB_B,
    ST_GRAB_C,
    ST_GRAB_D,
    ST_REL,
    ST_DIV_X,
    ST_DIV_Y,
    ST_HOLD,
    ST_GRAV_M,
    ST_GRAV_A,
    ST_MOVE_X,
    ST_MOVE_Y,
    ST_WALL,
    ST_BOUNCE,
    ST_FIN,
    ST_DONE
  } st_t;

  // divider request and response
  typedef struct packed {
    logic        start;
    logic [11:0] mag;
    logic        neg;
    logic [15:0] dt;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [VEL_W-1:0] quo;
  } div_rsp_t;

  // clamp a signed position to the unsigned 20-bit range
  function automatic logic [POS_W-1:0] sat_pos(input logic signed [31:0] v);
    if (v < 0) return '0;
    if (v > 32'sd1048575) return POS_MAX;
    return v[POS_W-1:0];
  endfunction

  // clamp a signed sum to the 24-bit velocity range
  function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [33:0] v);
    if (v < 34'(VEL_MIN)) return VEL_MIN;
    if (v > 34'(VEL_MAX)) return VEL_MAX;
    return v[VEL_W-1:0];
  endfunction

  // velocity times frame time, rounded toward minus infinity to whole steps of 2^-16
  function automatic logic signed [24:0] floor_move(input logic [39:0] m, input logic neg);
    logic [40:0] up;
    logic [24:0] q;
    up = 41'(m) + 41'd65535;
    q  = neg ? up[40:16] : {1'b0, m[39:16]};
    return neg ? -$signed(q) : $signed(q);
  endfunction

  // scaled magnitude with the sign reversed
  function automatic logic signed [VEL_W-1:0] bounce_vel(input logic [VEL_W-1:0] s,
                                                         input logic neg);
    return neg ? $signed(s) : -$signed(s);
  endfunction

  // reset position of a whole-pixel coordinate, clamped
  function automatic logic [POS_W-1:0] reset_pos(input int unsigned pix,
                                                  input int unsigned frac);
    logic [63:0] v;
    v = 64'(pix) << frac;
    return (v > 64'(POS_MAX)) ? POS_MAX : v[POS_W-1:0];
  endfunction

endpackage

### src/bbs_mul.sv
// bbs_mul: shared unsigned multiplier with a registered product.
// Depends on bbs_pkg for the operand width.
module bbs_mul import bbs_pkg::*; (
  input  logic                 clk,
  input  logic [MUL_W-1:0]     a,
  input  logic [MUL_W-1:0]     b,
  output logic [2*MUL_W-1:0]   prod
);

  // one product per cycle
  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

### src/bbs_div.sv
// bbs_div: restoring divider for the mouse velocity, one quotient bit per cycle.
// Depends on bbs_pkg for the request and response types.
module bbs_div import bbs_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int DIVW  = 12 + FRAC_BITS + 16;
  localparam int CNT_W = $clog2(DIV_STEPS);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [15:0]      rem;
  logic [23:0]      low;
  logic [23:0]      quo;
  logic             ovf;
  logic             zero;
  logic             neg;
  logic [15:0]      dt;

  logic [DIVW-1:0]  full;
  logic [DIVW-1:0]  hi;
  logic [16:0]      rem2;
  logic [16:0]      rem_sub;
  logic             ge;
  logic             big;
  logic [23:0]      magc;

  // dividend split: the part above the quotient bits tells overflow and seeds the remainder
  assign full    = DIVW'(req.mag) << (FRAC_BITS + 16);
  assign hi      = full >> 24;
  assign rem2    = {rem, low[23]};
  assign ge      = rem2 >= {1'b0, dt};
  assign rem_sub = rem2 - {1'b0, dt};

  // step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= hi[15:0];
      low  <= full[23:0];
      quo  <= '0;
      ovf  <= hi >= DIVW'(req.dt);
      zero <= req.dt == 16'd0;
      neg  <= req.neg;
      dt   <= req.dt;
    end else if (busy) begin
      rem <= ge ? rem_sub[15:0] : rem2[15:0];
      low <= {low[22:0], 1'b0};
      quo <= {quo[22:0], ge};
    end
  end

  // clamp and sign
  assign big  = ovf || (quo > VEL_MAG_LIM);
  assign magc = big ? VEL_MAG_LIM : quo;

  always_comb begin
    rsp.done = done;
    if (zero) begin
      rsp.quo = '0;
    end else if (neg) begin
      rsp.quo = -$signed(magc);
    end else if (magc == VEL_MAG_LIM) begin
      rsp.quo = VEL_MAX;
    end else begin
      rsp.quo = $signed(magc);
    end
  end

endmodule

### src/bouncing_ball_step_top.sv
// bouncing_ball_step_top: advances one ball by one frame per item under a small sequencer.
// Depends on bbs_pkg, bbs_mul and bbs_div.

// One item at a time: the block stalls its input from the accepting edge until the result has
// gone into the output register, and can take the next item in the cycle after that. A free ball
// runs the gravity, move and wall states, plus a bounce state for each wall hit (at most four). A
// press on a free ball adds the grab test, which also checks the squared distance when the point
// lies within the radius on both axes; a held ball goes straight to the hold state. A release of
// a held ball adds two 24-step divisions, whatever the frame time. The period is set by the single
// shared 24x24 multiplier, used once per product in turn, and the one-bit-per-cycle divider for
// the mouse velocity. The output register lets the block take the next item while a result still
// waits to be taken.
module bouncing_ball_step_top import bbs_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item,
  input  logic      cfg_en,
  input  logic [2:0] cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int CW = ((12 + FRAC_BITS > 24) ? 12 + FRAC_BITS : 24) + 3;
  localparam int AW = 2 * (8 + FRAC_BITS) + 1;
  localparam logic [POS_W-1:0] POS_X_RST = reset_pos(POS_X_RST_PIX, FRAC_BITS);
  localparam logic [POS_W-1:0] POS_Y_RST = reset_pos(POS_Y_RST_PIX, FRAC_BITS);

  typedef enum logic [1:0] {
    WALL_TOP,
    WALL_BOTTOM,
    WALL_LEFT,
    WALL_RIGHT
  } wall_t;

  // configuration
  logic [11:0] area_width;
  logic [11:0] area_height;
  logic [7:0]  ball_radius;
  logic [15:0] gravity;
  logic [15:0] restitution;

  // ball state
  logic [POS_W-1:0]        pos_x;
  logic [POS_W-1:0]        pos_y;
  logic signed [VEL_W-1:0] vel_x;
  logic signed [VEL_W-1:0] vel_y;
  logic                    grabbed;
  logic [11:0]             prev_mx;
  logic [11:0]             prev_my;

  // item in progress
  st_t             state;
  st_t             state_next;
  logic [15:0]     dt_r;
  logic [11:0]     mx_r;
  logic [11:0]     my_r;
  logic            rel_r;
  logic [11:0]     mdx_mag;
  logic [11:0]     mdy_mag;
  logic            mdx_neg;
  logic            mdy_neg;
  logic signed [CW-1:0] px;
  logic signed [CW-1:0] py;
  logic [AW-1:0]   acc;
  wall_t           wall;

  // shared units
  logic [MUL_W-1:0]   mul_a;
  logic [MUL_W-1:0]   mul_b;
  logic [2*MUL_W-1:0] prod;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  // combinational helpers
  logic signed [12:0]   ddx;
  logic signed [12:0]   ddy;
  logic signed [CW-1:0] mxq;
  logic signed [CW-1:0] myq;
  logic signed [CW-1:0] rq;
  logic signed [CW-1:0] wq;
  logic signed [CW-1:0] hq;
  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic signed [CW-1:0] dx_mag;
  logic signed [CW-1:0] dy_mag;
  logic                 near;
  logic [AW-1:0]        rsq;
  logic [VEL_W-1:0]     vx_mag;
  logic [VEL_W-1:0]     vy_mag;
  logic [31:0]          grav_inc;
  logic                 wall_hit;
  logic signed [CW-1:0] wall_pos;
  logic                 wall_is_x;
  logic                 in_acc;
  logic                 out_load;

  bbs_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  bbs_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // mouse movement since the previous item
  assign ddx = $signed({1'b0, in_item.mouse_x}) - $signed({1'b0, prev_mx});
  assign ddy = $signed({1'b0, in_item.mouse_y}) - $signed({1'b0, prev_my});

  // scaled coordinates
  assign mxq = $signed(CW'(mx_r) << FRAC_BITS);
  assign myq = $signed(CW'(my_r) << FRAC_BITS);
  assign rq  = $signed(CW'(ball_radius) << FRAC_BITS);
  assign wq  = $signed(CW'(area_width) << FRAC_BITS);
  assign hq  = $signed(CW'(area_height) << FRAC_BITS);

  // grab test distances; outside the radius on one axis already fails
  assign dx     = mxq - $signed(CW'(pos_x));
  assign dy     = myq - $signed(CW'(pos_y));
  assign dx_mag = dx[CW-1] ? -dx : dx;
  assign dy_mag = dy[CW-1] ? -dy : dy;
  assign near   = (dx_mag <= rq) && (dy_mag <= rq);
  assign rsq    = AW'(prod) << (2 * FRAC_BITS);

  // velocity magnitudes and gravity increment
  assign vx_mag   = vel_x[VEL_W-1] ? VEL_W'(-vel_x) : VEL_W'(vel_x);
  assign vy_mag   = vel_y[VEL_W-1] ? VEL_W'(-vel_y) : VEL_W'(vel_y);
  assign grav_inc = prod[31:0] >> (16 - FRAC_BITS);

  // wall checks, top, bottom, left, right
  assign wall_is_x = (wall == WALL_LEFT) || (wall == WALL_RIGHT);

  always_comb begin
    case (wall)
      WALL_TOP: begin
        wall_hit = py < rq;
        wall_pos = rq;
      end
      WALL_BOTTOM: begin
        wall_hit = (py + rq) > hq;
        wall_pos = hq - rq;
      end
      WALL_LEFT: begin
        wall_hit = px < rq;
        wall_pos = rq;
      end
      WALL_RIGHT: begin
        wall_hit = (px + rq) > wq;
        wall_pos = wq - rq;
      end
      default: begin
        wall_hit = 1'b0;
        wall_pos = rq;
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (in_item.button_pressed && !grabbed) ? ST_GRAB_A : ST_REL;
        end
      end
      ST_GRAB_A: state_next = near ? ST_GRAB_B : ST_REL;
      ST_GRAB_B: state_next = ST_GRAB_C;
      ST_GRAB_C: state_next = ST_GRAB_D;
      ST_GRAB_D: state_next = ST_REL;
      ST_REL: begin
        if (rel_r && grabbed) begin
          state_next = ST_DIV_X;
        end else if (grabbed) begin
          state_next = ST_HOLD;
        end else begin
          state_next = ST_GRAV_M;
        end
      end
      ST_DIV_X: begin
        if (div_rsp.done) state_next = ST_DIV_Y;
      end
      ST_DIV_Y: begin
        if (div_rsp.done) state_next = ST_GRAV_M;
      end
      ST_HOLD:   state_next = ST_DONE;
      ST_GRAV_M: state_next = ST_GRAV_A;
      ST_GRAV_A: state_next = ST_MOVE_X;
      ST_MOVE_X: state_next = ST_MOVE_Y;
      ST_MOVE_Y: state_next = ST_WALL;
      ST_WALL: begin
        if (wall_hit) begin
          state_next = ST_BOUNCE;
        end else if (wall == WALL_RIGHT) begin
          state_next = ST_FIN;
        end
      end
      ST_BOUNCE: state_next = (wall == WALL_RIGHT) ? ST_FIN : ST_WALL;
      ST_FIN:    state_next = ST_DONE;
      ST_DONE: begin
        if (out_load) state_next = ST_IDLE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs: handshake, multiplier operands, divider request
  always_comb begin
    in_stall = state != ST_IDLE;
    out_load = (state == ST_DONE) && (!out_valid || !out_stall);
    mul_a    = '0;
    mul_b    = '0;
    case (state)
      ST_GRAB_A: begin
        mul_a = MUL_W'(dx_mag);
        mul_b = MUL_W'(dx_mag);
      end
      ST_GRAB_B: begin
        mul_a = MUL_W'(dy_mag);
        mul_b = MUL_W'(dy_mag);
      end
      ST_GRAB_C: begin
        mul_a = MUL_W'(ball_radius);
        mul_b = MUL_W'(ball_radius);
      end
      ST_GRAV_M: begin
        mul_a = MUL_W'(gravity);
        mul_b = MUL_W'(dt_r);
      end
      ST_GRAV_A: begin
        mul_a = vx_mag;
        mul_b = MUL_W'(dt_r);
      end
      ST_MOVE_X: begin
        mul_a = vy_mag;
        mul_b = MUL_W'(dt_r);
      end
      ST_WALL: begin
        mul_a = wall_is_x ? vx_mag : vy_mag;
        mul_b = MUL_W'(restitution);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    div_req.start = ((state == ST_REL) && rel_r && grabbed) ||
                    ((state == ST_DIV_X) && div_rsp.done);
    div_req.mag   = (state == ST_DIV_X) ? mdy_mag : mdx_mag;
    div_req.neg   = (state == ST_DIV_X) ? mdy_neg : mdx_neg;
    div_req.dt    = dt_r;
  end

  assign in_acc = in_valid && !in_stall;

  // sequencer state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      area_width  <= AREA_WIDTH_RST;
      area_height <= AREA_HEIGHT_RST;
      ball_radius <= RADIUS_RST;
      gravity     <= GRAVITY_RST;
      restitution <= RESTITUTION_RST;
    end else begin
      state <= state_next;
      if (cfg_en) begin
        case (cfg_idx_t'(cfg_index))
          CFG_AREA_WIDTH:  area_width  <= cfg_data[11:0];
          CFG_AREA_HEIGHT: area_height <= cfg_data[11:0];
          CFG_RADIUS:      ball_radius <= cfg_data[7:0];
          CFG_GRAVITY:     gravity     <= cfg_data;
          CFG_RESTITUTION: restitution <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // ball state and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x   <= POS_X_RST;
      pos_y   <= POS_Y_RST;
      vel_x   <= '0;
      vel_y   <= '0;
      grabbed <= 1'b0;
      prev_mx <= '0;
      prev_my <= '0;
      wall    <= WALL_TOP;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            prev_mx <= in_item.mouse_x;
            prev_my <= in_item.mouse_y;
          end
        end
        ST_GRAB_D: begin
          if (acc <= rsq) grabbed <= 1'b1;
        end
        ST_DIV_X: begin
          if (div_rsp.done) vel_x <= div_rsp.quo;
        end
        ST_DIV_Y: begin
          if (div_rsp.done) begin
            vel_y   <= div_rsp.quo;
            grabbed <= 1'b0;
          end
        end
        ST_HOLD: begin
          pos_x <= sat_pos(32'(mxq));
          pos_y <= sat_pos(32'(myq));
          vel_x <= '0;
          vel_y <= '0;
        end
        ST_GRAV_A: begin
          vel_y <= sat_vel(34'(vel_y) + $signed({2'b00, grav_inc}));
        end
        ST_MOVE_Y: wall <= WALL_TOP;
        ST_WALL: begin
          if (!wall_hit) wall <= wall_t'(wall + 2'd1);
        end
        ST_BOUNCE: begin
          if (wall_is_x) begin
            vel_x <= bounce_vel(prod[39:16], vel_x[VEL_W-1]);
          end else begin
            vel_y <= bounce_vel(prod[39:16], vel_y[VEL_W-1]);
          end
          wall <= wall_t'(wall + 2'd1);
        end
        ST_FIN: begin
          pos_x <= sat_pos(32'(px));
          pos_y <= sat_pos(32'(py));
        end
        default: ;
      endcase
    end
  end

  // item fields and intermediate values
  always_ff @(posedge clk) begin
    if (in_acc) begin
      dt_r    <= in_item.frame_time;
      mx_r    <= in_item.mouse_x;
      my_r    <= in_item.mouse_y;
      rel_r   <= in_item.button_released;
      mdx_neg <= ddx[12];
      mdy_neg <= ddy[12];
      mdx_mag <= ddx[12] ? 12'(-ddx) : 12'(ddx);
      mdy_mag <= ddy[12] ? 12'(-ddy) : 12'(ddy);
    end
    case (state)
      ST_GRAB_B: acc <= AW'(prod);
      ST_GRAB_C: acc <= acc + AW'(prod);
      ST_MOVE_X: px  <= $signed(CW'(pos_x)) + CW'(floor_move(prod[39:0], vel_x[VEL_W-1]));
      ST_MOVE_Y: py  <= $signed(CW'(pos_y)) + CW'(floor_move(prod[39:0], vel_y[VEL_W-1]));
      ST_WALL: begin
        if (wall_hit) begin
          if (wall_is_x) begin
            px <= wall_pos;
          end else begin
            py <= wall_pos;
          end
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item.ball_x  <= pos_x;
      out_item.ball_y  <= pos_y;
      out_item.speed_x <= vel_x;
      out_item.speed_y <= vel_y;
      out_item.held    <= grabbed;
    end
  end

  // a held ball always reports zero velocity
  a_held_still: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.held |-> out_item.speed_x == '0 && out_item.speed_y == '0)
    else $error("held ball with nonzero speed");

  // the divider only finishes while the sequencer waits for it
  a_div_owned: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_DIV_X) || (state == ST_DIV_Y))
    else $error("divider result outside a division state");

  // an accepted item always starts the sequence
  a_item_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state != ST_IDLE)
    else $error("accepted item did not start the sequence");

endmodule

### verif/bouncing_ball_step_top_tb.sv
// bouncing_ball_step_top_tb: self-checking testbench of the bouncing ball step block.
// Depends on bbs_pkg and bouncing_ball_step_top; an in-line ball predictor checks each result.
module bouncing_ball_step_top_tb;
  import bbs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = FRAC_BITS_DEF;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_item_t   in_item = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_item;
  logic       cfg_en = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  bouncing_ball_step_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_en    (cfg_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predicted ball state and register copy
  logic [POS_W-1:0]        ball_px, ball_py;
  logic signed [VEL_W-1:0] ball_vx, ball_vy;
  logic                    ball_held;
  logic [11:0]             last_mx, last_my;
  logic [11:0]             reg_width, reg_height;
  logic [7:0]              reg_radius;
  logic [15:0]             reg_gravity, reg_restitution;

  out_item_t predicted_results[$];
  int  mismatches = 0;
  int  frames_sent = 0;
  int  cursor_x = 0;
  int  cursor_y = 0;
  int  hold_req = 0;
  bit  sender_idle = 1'b1;
  bit  receiver_idle = 1'b1;

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("FAIL bouncing_ball_step_top");
    $finish;
  end

  function automatic logic [POS_W-1:0] clamp_pos(input longint v);
    if (v < 0) return '0;
    if (v > longint'(POS_MAX)) return POS_MAX;
    return v[POS_W-1:0];
  endfunction

  function automatic logic signed [VEL_W-1:0] clamp_speed(input longint v);
    if (v < longint'(VEL_MIN)) return VEL_MIN;
    if (v > longint'(VEL_MAX)) return VEL_MAX;
    return v[VEL_W-1:0];
  endfunction

  // mouse velocity: pixel delta over frame time, truncated toward zero
  function automatic logic signed [VEL_W-1:0] mouse_speed(input logic [11:0] now_pix,
                                                          input logic [11:0] prev_pix,
                                                          input logic [15:0] dt);
    longint d, mag, q;
    if (dt == 0) return '0;
    d = longint'(now_pix) - longint'(prev_pix);
    mag = (d < 0 ? -d : d) << (FRAC + 16);
    q = mag / longint'(dt);
    if (q > longint'(VEL_MAG_LIM)) q = longint'(VEL_MAG_LIM);
    return clamp_speed(d < 0 ? -q : q);
  endfunction

  // wall hit: magnitude scaled by restitution, sign reversed
  function automatic logic signed [VEL_W-1:0] rebound(input logic signed [VEL_W-1:0] v);
    longint m, s;
    m = (v < 0) ? -longint'(v) : longint'(v);
    s = (m * longint'(reg_restitution)) >> 16;
    return clamp_speed(v < 0 ? s : -s);
  endfunction

  // advance the predicted ball by one frame and return the result it gives
  function automatic out_item_t advance_ball(input in_item_t it);
    longint dt, mxq, myq, rq, dx, dy, px, py, wq, hq, g;
    logic signed [VEL_W-1:0] throw_vx, throw_vy;
    out_item_t res;
    dt = longint'(it.frame_time);
    throw_vx = mouse_speed(it.mouse_x, last_mx, it.frame_time);
    throw_vy = mouse_speed(it.mouse_y, last_my, it.frame_time);
    mxq = longint'(it.mouse_x) << FRAC;
    myq = longint'(it.mouse_y) << FRAC;
    rq = longint'(reg_radius) << FRAC;
    last_mx = it.mouse_x;
    last_my = it.mouse_y;

    if (it.button_pressed) begin
      dx = mxq - longint'(ball_px);
      dy = myq - longint'(ball_py);
      if (dx * dx + dy * dy <= rq * rq) ball_held = 1'b1;
    end
    if (it.button_released && ball_held) begin
      ball_held = 1'b0;
      ball_vx = throw_vx;
      ball_vy = throw_vy;
    end

    if (ball_held) begin
      ball_px = clamp_pos(mxq);
      ball_py = clamp_pos(myq);
      ball_vx = '0;
      ball_vy = '0;
    end else begin
      wq = longint'(reg_width) << FRAC;
      hq = longint'(reg_height) << FRAC;
      g = (longint'(reg_gravity) * dt) >> (16 - FRAC);
      ball_vy = clamp_speed(longint'(ball_vy) + g);
      // arithmetic shift gives the floor of the product
      px = longint'(ball_px) + ((longint'(ball_vx) * dt) >>> 16);
      py = longint'(ball_py) + ((longint'(ball_vy) * dt) >>> 16);
      // walls in order: top, bottom, left, right
      if (py - rq < 0) begin
        py = rq;
        ball_vy = rebound(ball_vy);
      end
      if (py + rq > hq) begin
        py = hq - rq;
        ball_vy = rebound(ball_vy);
      end
      if (px - rq < 0) begin
        px = rq;
        ball_vx = rebound(ball_vx);
      end
      if (px + rq > wq) begin
        px = wq - rq;
        ball_vx = rebound(ball_vx);
      end
      ball_px = clamp_pos(px);
      ball_py = clamp_pos(py);
    end

    res.ball_x  = ball_px;
    res.ball_y  = ball_py;
    res.speed_x = ball_vx;
    res.speed_y = ball_vy;
    res.held    = ball_held;
    return res;
  endfunction

  // result check, register mirror and prediction of accepted items
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      ball_px = clamp_pos(longint'(POS_X_RST_PIX) << FRAC);
      ball_py = clamp_pos(longint'(POS_Y_RST_PIX) << FRAC);
      ball_vx = '0;
      ball_vy = '0;
      ball_held = 1'b0;
      last_mx = '0;
      last_my = '0;
      reg_width = AREA_WIDTH_RST;
      reg_height = AREA_HEIGHT_RST;
      reg_radius = RADIUS_RST;
      reg_gravity = GRAVITY_RST;
      reg_restitution = RESTITUTION_RST;
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_results.size() == 0) begin
          $error("result item with no item waiting for it");
          mismatches++;
        end else begin
          want = predicted_results.pop_front();
          if (out_item.ball_x !== want.ball_x) begin
            $error("ball_x: expected %0d, actual %0d", want.ball_x, out_item.ball_x);
            mismatches++;
          end
          if (out_item.ball_y !== want.ball_y) begin
            $error("ball_y: expected %0d, actual %0d", want.ball_y, out_item.ball_y);
            mismatches++;
          end
          if (out_item.speed_x !== want.speed_x) begin
            $error("speed_x: expected %0d, actual %0d", want.speed_x, out_item.speed_x);
            mismatches++;
          end
          if (out_item.speed_y !== want.speed_y) begin
            $error("speed_y: expected %0d, actual %0d", want.speed_y, out_item.speed_y);
            mismatches++;
          end
          if (out_item.held !== want.held) begin
            $error("held: expected %0d, actual %0d", want.held, out_item.held);
            mismatches++;
          end
        end
      end
      if (cfg_en) begin
        case (cfg_idx_t'(cfg_index))
          CFG_AREA_WIDTH:  reg_width = cfg_data[11:0];
          CFG_AREA_HEIGHT: reg_height = cfg_data[11:0];
          CFG_RADIUS:      reg_radius = cfg_data[7:0];
          CFG_GRAVITY:     reg_gravity = cfg_data;
          CFG_RESTITUTION: reg_restitution = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predicted_results.push_back(advance_ball(in_item));
    end
  end

  // result side: random stalls per item, plus a long hold when asked
  initial begin
    int n;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req > 0) begin
        n = hold_req;
        hold_req = 0;
      end else begin
        n = receiver_idle ? int'($urandom_range(0, 4)) : 0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  function automatic int clip_pix(input int v);
    if (v < 0) return 0;
    if (v > 4095) return 4095;
    return v;
  endfunction

  function automatic int jitter(input int a);
    return int'($urandom_range(0, 2 * a)) - a;
  endfunction

  // mostly short frames, some zero, some anywhere in range
  function automatic logic [15:0] draw_dt();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'($urandom_range(0, 65535));
      2:       return 16'hFFFF;
      default: return 16'($urandom_range(1, 2000));
    endcase
  endfunction

  // offer one item and wait until the block takes it
  task automatic send_frame(input logic [15:0] dt, input int mx, input int my,
                            input bit grab_btn, input bit drop_btn);
    in_item_t it;
    int gap;
    it.frame_time = dt;
    it.mouse_x = 12'(mx);
    it.mouse_y = 12'(my);
    it.button_pressed = grab_btn;
    it.button_released = drop_btn;
    gap = sender_idle ? int'($urandom_range(0, 4)) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    cursor_x = mx;
    cursor_y = my;
    frames_sent++;
  endtask

  // press near the predicted ball; dropping valid first lets the prediction catch up
  task automatic aimed_press(input bit drop_too, input int spread, input logic [15:0] dt);
    int cx, cy;
    in_valid <= 1'b0;
    @(posedge clk);
    cx = clip_pix(int'(ball_px >> FRAC) + jitter(spread));
    cy = clip_pix(int'(ball_py >> FRAC) + jitter(spread));
    send_frame(dt, cx, cy, 1'b1, drop_too);
  endtask

  // wait for all outstanding results, then let the sequencer fall idle
  task automatic settle();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    @(posedge clk);
    while (predicted_results.size() > 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (predicted_results.size() > 0) begin
      $error("%0d expected result items never arrived", predicted_results.size());
      mismatches++;
      predicted_results.delete();
    end
    repeat (100) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_idx_t idx, input logic [15:0] val);
    cfg_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic load_settings(input logic [11:0] w, input logic [11:0] h, input logic [7:0] r,
                               input logic [15:0] g, input logic [15:0] e);
    put_reg(CFG_AREA_WIDTH, 16'(w));
    put_reg(CFG_AREA_HEIGHT, 16'(h));
    put_reg(CFG_RADIUS, 16'(r));
    put_reg(CFG_GRAVITY, g);
    put_reg(CFG_RESTITUTION, e);
    cfg_en <= 1'b0;
  endtask

  // grab, drag, throw and let the ball fly
  task automatic throw_ball();
    int holds, frees;
    holds = $urandom_range(0, 5);
    frees = $urandom_range(1, 6);
    if ($urandom_range(0, 7) == 0) begin
      aimed_press(1'b1, int'(reg_radius) + 2, draw_dt());
    end else begin
      aimed_press(1'b0, int'(reg_radius) + 2, draw_dt());
      repeat (holds)
        send_frame(draw_dt(), clip_pix(cursor_x + jitter(40)), clip_pix(cursor_y + jitter(40)),
                   1'b0, 1'b0);
      send_frame(draw_dt(), clip_pix(cursor_x + jitter(200)), clip_pix(cursor_y + jitter(200)),
                 1'b0, 1'b1);
    end
    repeat (frees)
      send_frame(draw_dt(), clip_pix(cursor_x + jitter(20)), clip_pix(cursor_y + jitter(20)),
                 1'b0, 1'b0);
  endtask

  task automatic noise_frame();
    send_frame($urandom_range(0, 1) ? draw_dt() : 16'($urandom_range(0, 65535)),
               $urandom_range(0, 4095), $urandom_range(0, 4095),
               $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
  endtask

  // zero and full frame times, misses, grabs, saturated throws, bounces
  task automatic test_directed();
    load_settings(AREA_WIDTH_RST, AREA_HEIGHT_RST, RADIUS_RST, GRAVITY_RST, RESTITUTION_RST);
    send_frame(16'd0, 0, 0, 1'b0, 1'b0);
    send_frame(16'hFFFF, 4095, 4095, 1'b0, 1'b0);
    // press far from the ball, then a release with nothing held
    send_frame(16'd100, 0, 0, 1'b1, 1'b0);
    send_frame(16'd100, 0, 0, 1'b0, 1'b1);
    // grab, press again while held, drag to both corners
    aimed_press(1'b0, 0, 16'd655);
    send_frame(16'd655, cursor_x, cursor_y, 1'b1, 1'b0);
    send_frame(16'd1000, 0, 0, 1'b0, 1'b0);
    send_frame(16'd1000, 4095, 4095, 1'b0, 1'b0);
    // release on a zero frame time gives no throw speed
    send_frame(16'd0, 100, 100, 1'b0, 1'b1);
    // throw over the shortest frame saturates both speeds
    aimed_press(1'b0, 0, 16'd300);
    send_frame(16'd300, 400, 300, 1'b0, 1'b0);
    send_frame(16'd1, 4095, 0, 1'b0, 1'b1);
    repeat (4) send_frame(16'hFFFF, 4095, 0, 1'b0, 1'b0);
    // grab and let go in one frame
    aimed_press(1'b1, 0, 16'd655);
    send_frame(16'hFFFF, 2048, 2048, 1'b1, 1'b1);
    aimed_press(1'b0, 0, 16'd500);
    send_frame(16'd1, 0, 4095, 1'b0, 1'b1);
    repeat (2) send_frame(16'hFFFF, 0, 4095, 1'b0, 1'b0);
    settle();
  endtask

  task automatic test_throws(input int goal);
    while (frames_sent < goal) throw_ball();
    settle();
  endtask

  // area, radius, gravity and restitution at their extremes and in between
  task automatic test_settings_sweep();
    logic [11:0] w[5] = '{12'd1, 12'd4095, 12'd10, 12'd320, 12'd1600};
    logic [11:0] h[5] = '{12'd1, 12'd4095, 12'd8, 12'd240, 12'd1200};
    logic [7:0]  r[5] = '{8'd0, 8'd255, 8'd200, 8'd8, 8'd40};
    logic [15:0] g[5] = '{16'd0, 16'hFFFF, 16'd5000, 16'd2000, 16'd100};
    logic [15:0] e[5] = '{16'd0, 16'hFFFF, 16'd30000, 16'hFFFF, 16'd0};
    int goal;
    for (int i = 0; i < 5; i++) begin
      load_settings(w[i], h[i], r[i], g[i], e[i]);
      goal = frames_sent + 70;
      while (frames_sent < goal) begin
        if ($urandom_range(0, 3) == 0) noise_frame();
        else throw_ball();
      end
      settle();
    end
  endtask

  // unstructured items, first back to back, then with idling on both sides
  task automatic test_noise();
    load_settings(AREA_WIDTH_RST, AREA_HEIGHT_RST, RADIUS_RST, GRAVITY_RST, RESTITUTION_RST);
    sender_idle = 1'b0;
    receiver_idle = 1'b0;
    repeat (60) noise_frame();
    sender_idle = 1'b1;
    receiver_idle = 1'b1;
    repeat (60) noise_frame();
    settle();
  endtask

  // result side holds off while items keep coming, so the input stalls
  task automatic test_backpressure();
    sender_idle = 1'b0;
    hold_req = 300;
    repeat (12) noise_frame();
    sender_idle = 1'b1;
    settle();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_throws(350);
    test_settings_sweep();
    test_noise();
    test_backpressure();
    if (mismatches == 0) $display("PASS bouncing_ball_step_top");
    else $display("FAIL bouncing_ball_step_top");
    $finish;
  end

endmodule

### sim.f
src/bbs_pkg.sv
src/bbs_mul.sv
src/bbs_div.sv
src/bouncing_ball_step_top.sv
verif/bouncing_ball_step_top_tb.sv
